@@ hdl/tvl1_pkg.sv @@
`timescale 1ns / 1ps

package tvl1_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned TERM_W = SAMPLE_W + 2;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_DIM_W = 11;
  localparam int unsigned DSCALE_W = 17;
  localparam int unsigned TSCALE_W = 32;

  localparam int unsigned ROW_W = 10;
  localparam logic [CFG_DIM_W-1:0] MAX_PLANE_HEIGHT = 11'd1024;

  // Q16 scaling: sums split into a low word and a high part
  localparam int unsigned Q_FRAC = 16;
  localparam int unsigned LO_W = 32;
  localparam int unsigned HI_W = SUM_W - LO_W;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLVL_W = QPTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH    = 8'd0,
    REG_PLANE_HEIGHT = 8'd1,
    REG_DATA_SCALE   = 8'd2,
    REG_TV_SCALE     = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pred_sample;
    logic signed [SAMPLE_W-1:0] label_sample;
    logic                       batch_end;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0] loss_value;
    logic [SUM_W-1:0] tv_value;
    logic             saturated;
  } out_t;

  // position class of a pixel inside its row and plane
  typedef struct packed {
    logic first_col;
    logic last_col;
    logic first_row;
    logic last_row;
  } cls_t;

  // batch totals handed to the scaling pipeline
  typedef struct packed {
    logic [SUM_W-1:0] data_sum;
    logic [SUM_W-1:0] tv_sum;
    logic             sat;
  } acc_t;

  function automatic logic [SAMPLE_W-1:0] abs_diff(input logic signed [SAMPLE_W-1:0] a,
                                                   input logic signed [SAMPLE_W-1:0] b);
    logic [SAMPLE_W:0] d;
    logic [SAMPLE_W:0] m;
    d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    m = d[SAMPLE_W] ? (~d + 1'b1) : d;
    return m[SAMPLE_W-1:0];
  endfunction

endpackage

@@ hdl/tv_l1_loss_accumulator_unit.sv @@
`timescale 1ns / 1ps

// L1 data loss plus circular total-variation loss over a raster pixel stream.
// Sustained rate is one pixel pair per clock while the queue is not full. A
// finished result waits in the output register while the receiver holds stall,
// and pixels keep flowing; the back end freezes only when a second result
// reaches the output register while the first still waits (the front then
// keeps taking pixels until its 4-entry request queue fills). After its
// batch_end pixel is taken, a batch result passes through the queue, line-store
// read, accumulate, partial products, Q16 scaling, final sum and output register.
// The two line stores are MAX_ROW_WIDTH x 16 RAMs with one write and one read
// port each; they need no clearing after reset, so the block is ready at once.
// Row width and plane height are clamped to 1..MAX_ROW_WIDTH and 1..1024.
// Registers: 0 row_width, 1 plane_height, 2 data_scale (Q1.16),
// 3 tv_scale (Q16.16); write them only while no batch is in flight.
module tv_l1_loss_accumulator_unit import tvl1_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  in_t                   in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output out_t                  out_data_o,
  input  logic                  out_stall_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned ColW = $clog2(MAX_ROW_WIDTH);
  localparam int unsigned EntryW = $bits(in_t) + $bits(cls_t) + ColW;

  logic [CFG_DIM_W-1:0] row_width_q, plane_height_q;
  logic [DSCALE_W-1:0]  data_scale_q;
  logic [TSCALE_W-1:0]  tv_scale_q;
  logic                 cfg_we;

  logic              q_push, q_pop, q_valid, q_full;
  logic [QLVL_W-1:0] q_level;
  logic [EntryW-1:0] q_wdata, q_rdata;
  in_t               f_item, q_item;
  cls_t              f_cls, q_cls;
  logic [ColW-1:0]   f_col, q_col;

  logic en;
  logic acc_valid;
  acc_t acc;

  logic s_valid;
  out_t s_data;
  logic res_load;
  logic res_valid_q;
  out_t res_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    <= 11'd1024;
      plane_height_q <= 11'd1024;
      data_scale_q   <= 17'd65536;
      tv_scale_q     <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_ROW_WIDTH:    row_width_q    <= cfg_data_i[CFG_DIM_W-1:0];
        REG_PLANE_HEIGHT: plane_height_q <= cfg_data_i[CFG_DIM_W-1:0];
        REG_DATA_SCALE:   data_scale_q   <= cfg_data_i[DSCALE_W-1:0];
        REG_TV_SCALE:     tv_scale_q     <= cfg_data_i[TSCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign q_full = (q_level == QLVL_W'(QUEUE_DEPTH));

  tvl1_front #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .in_stall_o    (in_stall_o),
    .row_width_i   (row_width_q),
    .plane_height_i(plane_height_q),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .item_o        (f_item),
    .cls_o         (f_cls),
    .col_o         (f_col)
  );

  assign q_wdata = {f_item, f_cls, f_col};

  tvl1_queue #(
    .WIDTH(EntryW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata),
    .level_o(q_level)
  );

  assign {q_item, q_cls, q_col} = q_rdata;

  // back end moves as one unit unless a finished result cannot leave
  assign en = !(s_valid && res_valid_q && out_stall_i);

  tvl1_back #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_cls_i    (q_cls),
    .q_col_i    (q_col),
    .q_pop_o    (q_pop),
    .acc_valid_o(acc_valid),
    .acc_o      (acc)
  );

  tvl1_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .acc_valid_i (acc_valid),
    .acc_i       (acc),
    .data_scale_i(data_scale_q),
    .tv_scale_i  (tv_scale_q),
    .out_valid_o (s_valid),
    .out_data_o  (s_data)
  );

  // output register: holds one result so a stalled receiver does not stop pixels
  assign res_load = s_valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= s_data;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= QLVL_W'(QUEUE_DEPTH))
    else $error("request queue level beyond its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> (q_level == $past(q_level) + QLVL_W'(1)))
    else $error("request queue level did not count a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && !q_push) |=> (q_level == $past(q_level) - QLVL_W'(1)))
    else $error("request queue level did not count a pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && q_valid) |=> ($stable(q_col) || q_push || $past(q_push)))
    else $error("queue head changed while the back end was held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");
`endif

endmodule

@@ hdl/tvl1_ram.sv @@
`timescale 1ns / 1ps

module tvl1_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tvl1_queue.sv @@
`timescale 1ns / 1ps

module tvl1_queue import tvl1_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WIDTH-1:0]  data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [WIDTH-1:0]  data_o,
  output logic [QLVL_W-1:0] level_o
);

  logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QLVL_W-1:0] level_q, level_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    unique case ({push_i, pop_i})
      2'b10:   level_d = level_q + QLVL_W'(1);
      2'b01:   level_d = level_q - QLVL_W'(1);
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

endmodule

@@ hdl/tvl1_front.sv @@
`timescale 1ns / 1ps

module tvl1_front import tvl1_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = 1024,
  localparam int unsigned ColW = $clog2(MAX_ROW_WIDTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  in_t                  in_data_i,
  output logic                 in_stall_o,
  input  logic [CFG_DIM_W-1:0] row_width_i,
  input  logic [CFG_DIM_W-1:0] plane_height_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output in_t                  item_o,
  output cls_t                 cls_o,
  output logic [ColW-1:0]      col_o
);

  localparam int unsigned CmpW = (ColW + 1 > CFG_DIM_W) ? ColW + 1 : CFG_DIM_W;

  logic [ColW-1:0]      col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [CmpW-1:0]      w_eff;
  logic [CFG_DIM_W-1:0] h_eff;
  logic                 last_col, last_row;

  // out-of-range sizes are clamped into the supported window
  always_comb begin
    priority if (row_width_i == '0) begin
      w_eff = CmpW'(1);
    end else if (CmpW'(row_width_i) > CmpW'(MAX_ROW_WIDTH)) begin
      w_eff = CmpW'(MAX_ROW_WIDTH);
    end else begin
      w_eff = CmpW'(row_width_i);
    end
    priority if (plane_height_i == '0) begin
      h_eff = CFG_DIM_W'(1);
    end else if (plane_height_i > MAX_PLANE_HEIGHT) begin
      h_eff = MAX_PLANE_HEIGHT;
    end else begin
      h_eff = plane_height_i;
    end
  end

  assign last_col = (CmpW'(col_q) + CmpW'(1)) >= w_eff;
  assign last_row = (CFG_DIM_W'(row_q) + CFG_DIM_W'(1)) >= h_eff;

  assign push_o     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign item_o     = in_data_i;
  assign col_o      = col_q;

  always_comb begin
    cls_o.first_col = (col_q == '0);
    cls_o.last_col  = last_col;
    cls_o.first_row = (row_q == '0);
    cls_o.last_row  = last_row;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      priority if (in_data_i.batch_end) begin
        col_d = '0;
        row_d = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ hdl/tvl1_back.sv @@
`timescale 1ns / 1ps

module tvl1_back import tvl1_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = 1024,
  localparam int unsigned ColW = $clog2(MAX_ROW_WIDTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            q_valid_i,
  input  in_t             q_item_i,
  input  cls_t            q_cls_i,
  input  logic [ColW-1:0] q_col_i,
  output logic            q_pop_o,
  output logic            acc_valid_o,
  output acc_t            acc_o
);

  logic            a_valid_q;
  in_t             a_item_q;
  cls_t            a_cls_q;
  logic [ColW-1:0] a_col_q;

  logic                       prev_we, first_we;
  logic signed [SAMPLE_W-1:0] prev_rd, first_rd;
  logic                       fwd_prev_hit_q, fwd_first_hit_q;
  logic signed [SAMPLE_W-1:0] fwd_pix_q;

  logic signed [SAMPLE_W-1:0] rfp_q, prev_pix_q;
  logic [SUM_W-1:0]           data_sum_q, tv_sum_q;
  logic                       sat_q;

  logic signed [SAMPLE_W-1:0] p, rfp_eff, up_pix, top_pix;
  logic [SAMPLE_W-1:0]        h1, h2, v1, v2;
  logic [TERM_W-1:0]          tv_terms;
  logic [SUM_W:0]             tv_total, data_total;
  logic [SUM_W-1:0]           tv_new, data_new;
  logic                       sat_new;
  logic                       a_fire;

  logic acc_valid_q;
  acc_t acc_q;

  assign q_pop_o = en_i && q_valid_i;
  assign a_fire  = en_i && a_valid_q;

  assign prev_we  = a_fire;
  assign first_we = a_fire && a_cls_q.first_row;

  tvl1_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_ROW_WIDTH)
  ) u_prev_row (
    .clk_i  (clk_i),
    .we_i   (prev_we),
    .waddr_i(a_col_q),
    .wdata_i(a_item_q.pred_sample),
    .re_i   (q_pop_o),
    .raddr_i(q_col_i),
    .rdata_o(prev_rd)
  );

  tvl1_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_ROW_WIDTH)
  ) u_first_row (
    .clk_i  (clk_i),
    .we_i   (first_we),
    .waddr_i(a_col_q),
    .wdata_i(a_item_q.pred_sample),
    .re_i   (q_pop_o),
    .raddr_i(q_col_i),
    .rdata_o(first_rd)
  );

  // a one-pixel row reads the column that the pixel ahead is writing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_prev_hit_q  <= 1'b0;
      fwd_first_hit_q <= 1'b0;
    end else if (q_pop_o) begin
      fwd_prev_hit_q  <= prev_we && (a_col_q == q_col_i);
      fwd_first_hit_q <= first_we && (a_col_q == q_col_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      fwd_pix_q <= a_item_q.pred_sample;
      a_item_q  <= q_item_i;
      a_cls_q   <= q_cls_i;
      a_col_q   <= q_col_i;
    end
  end

  always_comb begin
    p        = a_item_q.pred_sample;
    rfp_eff  = a_cls_q.first_col ? p : rfp_q;
    up_pix   = fwd_prev_hit_q ? fwd_pix_q : prev_rd;
    top_pix  = a_cls_q.first_row ? p : (fwd_first_hit_q ? fwd_pix_q : first_rd);
    h1       = a_cls_q.first_col ? '0 : abs_diff(p, prev_pix_q);
    h2       = a_cls_q.last_col ? abs_diff(rfp_eff, p) : '0;
    v1       = a_cls_q.first_row ? '0 : abs_diff(p, up_pix);
    v2       = a_cls_q.last_row ? abs_diff(top_pix, p) : '0;
    tv_terms = TERM_W'(h1) + TERM_W'(h2) + TERM_W'(v1) + TERM_W'(v2);

    // terms are small, so a carry out of the sum marks the clamp
    tv_total   = {1'b0, tv_sum_q} + (SUM_W + 1)'(tv_terms);
    data_total = {1'b0, data_sum_q} +
                 (SUM_W + 1)'(abs_diff(p, a_item_q.label_sample));
    tv_new   = tv_total[SUM_W] ? '1 : tv_total[SUM_W-1:0];
    data_new = data_total[SUM_W] ? '1 : data_total[SUM_W-1:0];
    sat_new  = sat_q || tv_total[SUM_W] || data_total[SUM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      acc_valid_q <= 1'b0;
      rfp_q       <= '0;
      prev_pix_q  <= '0;
      data_sum_q  <= '0;
      tv_sum_q    <= '0;
      sat_q       <= 1'b0;
    end else if (en_i) begin
      a_valid_q   <= q_valid_i;
      acc_valid_q <= a_valid_q && a_item_q.batch_end;
      if (a_valid_q) begin
        if (a_item_q.batch_end) begin
          rfp_q      <= '0;
          prev_pix_q <= '0;
          data_sum_q <= '0;
          tv_sum_q   <= '0;
          sat_q      <= 1'b0;
        end else begin
          rfp_q      <= rfp_eff;
          prev_pix_q <= p;
          data_sum_q <= data_new;
          tv_sum_q   <= tv_new;
          sat_q      <= sat_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire && a_item_q.batch_end) begin
      acc_q.data_sum <= data_new;
      acc_q.tv_sum   <= tv_new;
      acc_q.sat      <= sat_new;
    end
  end

  assign acc_valid_o = acc_valid_q;
  assign acc_o       = acc_q;

endmodule

@@ hdl/tvl1_scale.sv @@
`timescale 1ns / 1ps

module tvl1_scale import tvl1_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                acc_valid_i,
  input  acc_t                acc_i,
  input  logic [DSCALE_W-1:0] data_scale_i,
  input  logic [TSCALE_W-1:0] tv_scale_i,
  output logic                out_valid_o,
  output out_t                out_data_o
);

  localparam int unsigned DhW = HI_W + DSCALE_W;
  localparam int unsigned DlW = LO_W + DSCALE_W;
  localparam int unsigned ThW = HI_W + TSCALE_W;
  localparam int unsigned TlW = LO_W + TSCALE_W;
  localparam int unsigned KeepW = SUM_W - Q_FRAC;

  // partial products
  logic           prod_valid_q;
  logic [DhW-1:0] dh_q;
  logic [DlW-1:0] dl_q;
  logic [ThW-1:0] th_q;
  logic [TlW-1:0] tl_q;
  logic           prod_sat_q;

  // scaled terms
  logic             part_valid_q;
  logic [SUM_W-1:0] d_q, t_q;
  logic             part_sat_q;

  logic             d_hi_ovf, t_hi_ovf;
  logic [SUM_W:0]   d_add, t_add, s_add;
  logic [SUM_W-1:0] d_val, t_val;
  logic             part_sat;

  logic out_valid_q;
  out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dh_q       <= DhW'(acc_i.data_sum[SUM_W-1:LO_W]) * DhW'(data_scale_i);
      dl_q       <= DlW'(acc_i.data_sum[LO_W-1:0]) * DlW'(data_scale_i);
      th_q       <= ThW'(acc_i.tv_sum[SUM_W-1:LO_W]) * ThW'(tv_scale_i);
      tl_q       <= TlW'(acc_i.tv_sum[LO_W-1:0]) * TlW'(tv_scale_i);
      prod_sat_q <= acc_i.sat;
    end
  end

  // floor(x * scale / 2^16): the high product must fit before its shift
  always_comb begin
    d_hi_ovf = |dh_q[DhW-1:KeepW];
    t_hi_ovf = |th_q[ThW-1:KeepW];
    d_add    = {1'b0, dh_q[KeepW-1:0], {Q_FRAC{1'b0}}} + (SUM_W + 1)'(dl_q[DlW-1:Q_FRAC]);
    t_add    = {1'b0, th_q[KeepW-1:0], {Q_FRAC{1'b0}}} + (SUM_W + 1)'(tl_q[TlW-1:Q_FRAC]);
    d_val    = (d_hi_ovf || d_add[SUM_W]) ? '1 : d_add[SUM_W-1:0];
    t_val    = (t_hi_ovf || t_add[SUM_W]) ? '1 : t_add[SUM_W-1:0];
    part_sat = prod_sat_q || d_hi_ovf || d_add[SUM_W] || t_hi_ovf || t_add[SUM_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q        <= d_val;
      t_q        <= t_val;
      part_sat_q <= part_sat;
    end
  end

  assign s_add = {1'b0, d_q} + {1'b0, t_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.loss_value <= s_add[SUM_W] ? '1 : s_add[SUM_W-1:0];
      out_q.tv_value   <= t_q;
      out_q.saturated  <= part_sat_q || s_add[SUM_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      part_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (en_i) begin
      prod_valid_q <= acc_valid_i;
      part_valid_q <= prod_valid_q;
      out_valid_q  <= part_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
